// ----- hw/rtl/flt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flt_pkg: shared definitions for the failed-attempt lockout table
// Field widths, register codes and reset values, request actions, the config
// and table entry structs, and the key normalization function.
// ----------------------------------------------------------------------------
package flt_pkg;

  localparam int unsigned FLT_SLOTS  = 8;
  localparam int unsigned KEY_LO_W   = 64;
  localparam int unsigned KEY_HI_W   = 40;
  localparam int unsigned KEY_W      = KEY_LO_W + KEY_HI_W;
  localparam int unsigned KEY_BYTES  = KEY_W / 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned SLOT_OUT_W = 3;
  localparam int unsigned CFG_AW     = 4;
  localparam int unsigned CFG_DW     = 32;

  localparam logic [TIME_W-1:0] WINDOW_RST  = 32'd60000;
  localparam logic [TIME_W-1:0] LOCKOUT_RST = 32'd30000;
  localparam logic [CNT_W-1:0]  LIMIT_RST   = 8'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 8'd255;

  // Register index codes (byte address / 4)
  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_LOCKOUT = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;

  typedef enum logic [1:0] {
    ACT_CHECK      = 2'd0,
    ACT_FAIL       = 2'd1,
    ACT_CLEAR_USER = 2'd2,
    ACT_CLEAR_ALL  = 2'd3
  } flt_action_t;

  typedef struct packed {
    logic [TIME_W-1:0] window_ms;
    logic [TIME_W-1:0] lockout_ms;
    logic [CNT_W-1:0]  fail_limit;
  } flt_cfg_t;

  typedef struct packed {
    logic [KEY_LO_W-1:0] key_lo;
    logic [KEY_HI_W-1:0] key_hi;
    logic [CNT_W-1:0]    cnt;
    logic [TIME_W-1:0]   wstart;
    logic [TIME_W-1:0]   lend;
  } flt_entry_t;

  // Zero every byte after the first zero byte of the key.
  function automatic logic [KEY_W-1:0] flt_norm_key(input logic [KEY_W-1:0] key);
    logic [KEY_BYTES-1:0] nz;
    logic                 keep;
    logic [KEY_W-1:0]     res;
    for (int i = 0; i < KEY_BYTES; i++) begin
      nz[i] = |key[8*i +: 8];
    end
    res = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      keep = 1'b1;
      for (int j = 0; j < i; j++) begin
        keep = keep & nz[j];
      end
      if (keep) begin
        res[8*i +: 8] = key[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/flt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flt_in_if: request channel of the lockout table
// Valid/ready handshake carrying the action, key and current time.
// ----------------------------------------------------------------------------
interface flt_in_if;
  logic                                valid;
  logic                                ready;
  flt_pkg::flt_action_t                action;
  logic [flt_pkg::KEY_LO_W-1:0]        key_low;
  logic [flt_pkg::KEY_HI_W-1:0]        key_high;
  logic [flt_pkg::TIME_W-1:0]          now_ms;

  modport source (output valid, action, key_low, key_high, now_ms, input ready);
  modport sink (input valid, action, key_low, key_high, now_ms, output ready);
endinterface

// ----- hw/rtl/flt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flt_out_if: result channel of the lockout table
// Valid/ready handshake carrying lock status, count and slot.
// ----------------------------------------------------------------------------
interface flt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              locked;
  logic                              lockout_started;
  logic [flt_pkg::CNT_W-1:0]         fail_count;
  logic [flt_pkg::SLOT_OUT_W-1:0]    slot_index;

  modport source (output valid, locked, lockout_started, fail_count, slot_index,
                  input ready);
  modport sink (input valid, locked, lockout_started, fail_count, slot_index,
                output ready);
endinterface

// ----- hw/rtl/flt_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flt_cfg: APB configuration registers
// Holds window length, lockout length and failure limit; zero wait states.
// ----------------------------------------------------------------------------
module flt_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [flt_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [flt_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [flt_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready,
  output flt_pkg::flt_cfg_t            cfg_o
);

  flt_pkg::flt_cfg_t cfg_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ms  <= flt_pkg::WINDOW_RST;
      cfg_r.lockout_ms <= flt_pkg::LOCKOUT_RST;
      cfg_r.fail_limit <= flt_pkg::LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        flt_pkg::REG_WINDOW:  cfg_r.window_ms  <= cfg_pwdata;
        flt_pkg::REG_LOCKOUT: cfg_r.lockout_ms <= cfg_pwdata;
        flt_pkg::REG_LIMIT:   cfg_r.fail_limit <= cfg_pwdata[flt_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      flt_pkg::REG_WINDOW:  cfg_prdata = cfg_r.window_ms;
      flt_pkg::REG_LOCKOUT: cfg_prdata = cfg_r.lockout_ms;
      flt_pkg::REG_LIMIT:   cfg_prdata = {{(flt_pkg::CFG_DW - flt_pkg::CNT_W){1'b0}},
                                          cfg_r.fail_limit};
      default:              cfg_prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/failure_lockout_table_top.sv -----
`timescale 1ns / 1ps
// Sequence: clear all goes from idle straight to the write state; clear user walks
// the slots first, check adds OP_A, and record failure adds OP_A, OP_B and OP_C.
// Throughput: one request at a time; the slot walk reads one table entry per
// cycle from a single-port table, and one 33-bit adder does the time compares and sums.
// Reset: config registers take their defaults and all slots read as empty
// (per-slot valid bits clear at once, no clearing pass).
// ----------------------------------------------------------------------------
// failure_lockout_table_top: per-key failed-attempt lockout table
// Sequencer walking the slot table for match / allocation, then updating the
// selected slot through a shared adder.
// ----------------------------------------------------------------------------
module failure_lockout_table_top #(
  parameter int unsigned SLOTS = flt_pkg::FLT_SLOTS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  flt_in_if.sink                       in_req,
  flt_out_if.source                    out_rsp,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [flt_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [flt_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [flt_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned TW = flt_pkg::TIME_W;
  localparam int unsigned NW = flt_pkg::CNT_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_OP_A  = 6'b000100,
    ST_OP_B  = 6'b001000,
    ST_OP_C  = 6'b010000,
    ST_WRITE = 6'b100000
  } state_t;

  flt_pkg::flt_cfg_t cfg;

  flt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  state_t state_r, state_nxt;

  flt_pkg::flt_action_t        action_r;
  logic [flt_pkg::KEY_W-1:0]   key_r;
  logic [TW-1:0]               now_r;

  // table storage
  flt_pkg::flt_entry_t mem [SLOTS];
  logic [SLOTS-1:0]    slot_valid_r;

  // walk
  logic [CW-1:0]       rd_cnt_r;
  logic [SW-1:0]       rd_addr;
  logic                rd_issue;
  flt_pkg::flt_entry_t rd_data_r;
  logic                rd_valid_r;
  logic                cmp_go_r;
  logic [SW-1:0]       cmp_idx_r;
  flt_pkg::flt_entry_t eff;
  logic                key_hit;
  logic                scan_done;

  logic                found_r;
  logic [SW-1:0]       match_idx_r;
  logic [NW-1:0]       match_cnt_r;
  logic [TW-1:0]       match_ws_r;
  logic [TW-1:0]       match_le_r;
  logic                empty_r;
  logic [SW-1:0]       pick_r;
  logic [TW-1:0]       pick_ws_r;

  logic [SW-1:0]       sel_slot;
  logic [SW+2:0]       slot_ext;
  logic [NW-1:0]       base_cnt;
  logic [TW-1:0]       base_ws;
  logic [TW-1:0]       base_le;

  // shared adder
  logic [TW-1:0]       alu_a;
  logic [TW-1:0]       alu_b;
  logic                alu_sub;
  logic [TW:0]         alu_sum;

  // update stage
  logic [TW-1:0]       d_r;
  logic                locked_r;
  logic                started_r;
  logic [NW-1:0]       cnt_new_r;
  logic [TW-1:0]       ws_new_r;
  logic [TW-1:0]       le_new_r;
  logic                restart;
  logic [NW-1:0]       cnt_c0;
  logic [NW-1:0]       cnt_c1;

  logic                in_fire;
  logic                wr_go;
  flt_pkg::flt_entry_t wr_entry;

  logic                out_valid_r;
  logic                out_locked_r;
  logic                out_started_r;
  logic [NW-1:0]       out_cnt_r;
  logic [flt_pkg::SLOT_OUT_W-1:0] out_slot_r;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid & in_req.ready;
  assign wr_go        = (state_r == ST_WRITE) & (~out_valid_r | out_rsp.ready);

  assign rd_addr   = rd_cnt_r[SW-1:0];
  assign rd_issue  = (state_r == ST_SCAN) && (rd_cnt_r != CW'(SLOTS));
  assign eff       = rd_valid_r ? rd_data_r : '0;
  assign key_hit   = (eff.key_lo == key_r[flt_pkg::KEY_LO_W-1:0]) &&
                     (eff.key_hi == key_r[flt_pkg::KEY_W-1:flt_pkg::KEY_LO_W]);
  assign scan_done = cmp_go_r && (cmp_idx_r == SW'(SLOTS - 1));

  assign sel_slot = found_r ? match_idx_r : pick_r;
  assign slot_ext = {3'b000, sel_slot};
  assign base_cnt = found_r ? match_cnt_r : '0;
  assign base_ws  = found_r ? match_ws_r  : '0;
  assign base_le  = found_r ? match_le_r  : '0;

  always_comb begin
    alu_a   = now_r;
    alu_b   = base_ws;
    alu_sub = 1'b1;
    case (state_r)
      ST_SCAN: begin
        alu_a = eff.wstart;
        alu_b = pick_ws_r;
      end
      ST_OP_A: begin
        alu_b = (action_r == flt_pkg::ACT_CHECK) ? base_le : base_ws;
      end
      ST_OP_B: begin
        alu_a = cfg.window_ms;
        alu_b = d_r;
      end
      ST_OP_C: begin
        alu_b   = cfg.lockout_ms;
        alu_sub = 1'b0;
      end
      default: ;
    endcase
  end

  // carry out high means a >= b on a subtract
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} +
                   {{TW{1'b0}}, alu_sub};

  assign restart = ~alu_sum[TW];
  assign cnt_c0  = restart ? '0 : base_cnt;
  assign cnt_c1  = (cnt_c0 == flt_pkg::CNT_MAX) ? cnt_c0 : cnt_c0 + 8'd1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_req.action == flt_pkg::ACT_CLEAR_ALL) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = (action_r == flt_pkg::ACT_CLEAR_USER) ? ST_WRITE : ST_OP_A;
        end
      end
      ST_OP_A:  state_nxt = (action_r == flt_pkg::ACT_CHECK) ? ST_WRITE : ST_OP_B;
      ST_OP_B:  state_nxt = ST_OP_C;
      ST_OP_C:  state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (wr_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_valid_r <= '0;
      out_valid_r  <= 1'b0;
      cmp_go_r     <= 1'b0;
      found_r      <= 1'b0;
      empty_r      <= 1'b0;
      rd_cnt_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      cmp_go_r <= rd_issue;
      if (in_fire) begin
        rd_cnt_r <= '0;
        found_r  <= 1'b0;
        empty_r  <= 1'b0;
      end else if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + CW'(1);
      end
      if (cmp_go_r) begin
        if (!found_r && key_hit) begin
          found_r <= 1'b1;
        end
        if (!empty_r && (eff.key_lo[7:0] == 8'd0)) begin
          empty_r <= 1'b1;
        end
      end
      if (wr_go) begin
        out_valid_r <= 1'b1;
        case (action_r)
          flt_pkg::ACT_CLEAR_ALL:  slot_valid_r <= '0;
          flt_pkg::ACT_CLEAR_USER: slot_valid_r[sel_slot] <= 1'b0;
          default:                 slot_valid_r[sel_slot] <= 1'b1;
        endcase
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture, walk and update datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r <= in_req.action;
      key_r    <= flt_pkg::flt_norm_key({in_req.key_high, in_req.key_low});
      now_r    <= in_req.now_ms;
    end
    if (rd_issue) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= slot_valid_r[rd_addr];
      cmp_idx_r  <= rd_addr;
    end
    if (cmp_go_r) begin
      if (!found_r && key_hit) begin
        match_idx_r <= cmp_idx_r;
        match_cnt_r <= eff.cnt;
        match_ws_r  <= eff.wstart;
        match_le_r  <= eff.lend;
      end
      if (!empty_r) begin
        if (eff.key_lo[7:0] == 8'd0) begin
          pick_r <= cmp_idx_r;
        end else if ((cmp_idx_r == '0) || !alu_sum[TW]) begin
          // take the strictly older window start; first slot seeds the search
          pick_r    <= cmp_idx_r;
          pick_ws_r <= eff.wstart;
        end
      end
    end
    case (state_r)
      ST_OP_A: begin
        locked_r <= (base_le != '0) && alu_sum[TW-1];
        d_r      <= alu_sum[TW-1:0];
      end
      ST_OP_B: begin
        cnt_new_r <= cnt_c1;
        ws_new_r  <= restart ? now_r : base_ws;
        started_r <= (cnt_c1 >= cfg.fail_limit);
      end
      ST_OP_C: begin
        le_new_r <= started_r ? alu_sum[TW-1:0] : base_le;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_entry.key_lo = key_r[flt_pkg::KEY_LO_W-1:0];
    wr_entry.key_hi = key_r[flt_pkg::KEY_W-1:flt_pkg::KEY_LO_W];
    if (action_r == flt_pkg::ACT_FAIL) begin
      wr_entry.cnt    = cnt_new_r;
      wr_entry.wstart = ws_new_r;
      wr_entry.lend   = le_new_r;
    end else begin
      wr_entry.cnt    = base_cnt;
      wr_entry.wstart = base_ws;
      wr_entry.lend   = base_le;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go && ((action_r == flt_pkg::ACT_CHECK) || (action_r == flt_pkg::ACT_FAIL))) begin
      mem[sel_slot] <= wr_entry;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (wr_go) begin
      out_locked_r  <= (action_r == flt_pkg::ACT_CHECK) & locked_r;
      out_started_r <= (action_r == flt_pkg::ACT_FAIL) & started_r;
      case (action_r)
        flt_pkg::ACT_CHECK: out_cnt_r <= base_cnt;
        flt_pkg::ACT_FAIL:  out_cnt_r <= cnt_new_r;
        default:            out_cnt_r <= '0;
      endcase
      out_slot_r <= (action_r == flt_pkg::ACT_CLEAR_ALL) ? '0
                                                          : slot_ext[flt_pkg::SLOT_OUT_W-1:0];
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.locked          = out_locked_r;
  assign out_rsp.lockout_started = out_started_r;
  assign out_rsp.fail_count      = out_cnt_r;
  assign out_rsp.slot_index      = out_slot_r;

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_req.ready)
    else $error("request taken while previous one still in progress");

  a_clear_all_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_go && (action_r == flt_pkg::ACT_CLEAR_ALL)) |=> (slot_valid_r == '0))
    else $error("clear all left a slot occupied");

  a_started_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_started_r) |-> (out_cnt_r >= cfg.fail_limit))
    else $error("lockout started below the failure limit");

  a_lock_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_locked_r && out_started_r))
    else $error("locked and lockout_started both set");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OP_A) |-> (sel_slot <= SW'(SLOTS - 1)))
    else $error("selected slot beyond table depth");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the failed-attempt lockout table
// Drives check / record-failure / clear requests through the request channel
// and register writes through the APB port, predicts each verdict from a
// private copy of the slot table and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NSLOT      = flt_pkg::FLT_SLOTS;
  localparam int unsigned LAT_CYCLES = NSLOT + 6;
  localparam int unsigned MAX_CYCLES = 400000;
  localparam int unsigned POOL       = 12;

  typedef struct packed {
    logic                           locked;
    logic                           started;
    logic [flt_pkg::CNT_W-1:0]      count;
    logic [flt_pkg::SLOT_OUT_W-1:0] slot;
  } verdict_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [flt_pkg::CFG_AW-1:0] cfg_paddr;
  logic [flt_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [flt_pkg::CFG_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  flt_in_if  req_if ();
  flt_out_if rsp_if ();

  failure_lockout_table_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_if),
    .out_rsp     (rsp_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow slot table and registers
  logic [flt_pkg::KEY_LO_W-1:0] tbl_key_lo [NSLOT];
  logic [flt_pkg::KEY_HI_W-1:0] tbl_key_hi [NSLOT];
  logic [flt_pkg::CNT_W-1:0]    tbl_cnt    [NSLOT];
  logic [flt_pkg::TIME_W-1:0]   tbl_wstart [NSLOT];
  logic [flt_pkg::TIME_W-1:0]   tbl_lend   [NSLOT];
  logic [flt_pkg::TIME_W-1:0]   cur_window;
  logic [flt_pkg::TIME_W-1:0]   cur_lockout;
  logic [flt_pkg::CNT_W-1:0]    cur_limit;

  verdict_t                   verdict_q [$];
  logic [flt_pkg::KEY_W-1:0]  user_pool [POOL];
  logic [flt_pkg::TIME_W-1:0] clock_ms;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned req_sent;
  int unsigned rsp_checked;
  int unsigned lockouts_started;
  int unsigned locked_hits;
  bit          source_gaps;
  bit          sink_stalls;
  int unsigned stall_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t: timeout, %0d results still owed", $time, verdict_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic void empty_slot(int unsigned s);
    tbl_key_lo[s] = '0;
    tbl_key_hi[s] = '0;
    tbl_cnt[s]    = '0;
    tbl_wstart[s] = '0;
    tbl_lend[s]   = '0;
  endfunction

  // A name ends at its first zero byte; drop whatever follows.
  function automatic logic [flt_pkg::KEY_W-1:0] trim_key(logic [flt_pkg::KEY_W-1:0] raw);
    logic [flt_pkg::KEY_W-1:0] k;
    logic                      ended;
    k     = raw;
    ended = 1'b0;
    for (int i = 0; i < flt_pkg::KEY_BYTES; i++) begin
      if (ended) k[8*i +: 8] = 8'h00;
      else if (k[8*i +: 8] == 8'h00) ended = 1'b1;
    end
    return k;
  endfunction

  function automatic int unsigned claim_slot(logic [flt_pkg::KEY_W-1:0] key);
    int unsigned pick;
    pick = 0;
    for (int s = 0; s < NSLOT; s++) begin
      if ({tbl_key_hi[s], tbl_key_lo[s]} == key) return s;
    end
    // first empty slot, else oldest window start, lowest index on ties
    for (int s = 0; s < NSLOT; s++) begin
      if (tbl_key_lo[s][7:0] == 8'h00) begin
        pick = s;
        break;
      end
      if (tbl_wstart[s] < tbl_wstart[pick]) pick = s;
    end
    empty_slot(pick);
    {tbl_key_hi[pick], tbl_key_lo[pick]} = key;
    return pick;
  endfunction

  function automatic verdict_t lockout_verdict(flt_pkg::flt_action_t act,
                                               logic [flt_pkg::KEY_W-1:0] raw_key,
                                               logic [flt_pkg::TIME_W-1:0] now);
    verdict_t                   v;
    int unsigned                s;
    logic [flt_pkg::TIME_W-1:0] span;
    v = '0;
    if (act == flt_pkg::ACT_CLEAR_ALL) begin
      for (int i = 0; i < NSLOT; i++) empty_slot(i);
      return v;
    end
    s      = claim_slot(trim_key(raw_key));
    v.slot = s[flt_pkg::SLOT_OUT_W-1:0];
    case (act)
      flt_pkg::ACT_CHECK: begin
        span     = now - tbl_lend[s];
        v.locked = (tbl_lend[s] != '0) && span[flt_pkg::TIME_W-1];
        v.count  = tbl_cnt[s];
      end
      flt_pkg::ACT_FAIL: begin
        span = now - tbl_wstart[s];
        if (span > cur_window) begin
          tbl_wstart[s] = now;
          tbl_cnt[s]    = '0;
        end
        if (tbl_cnt[s] != flt_pkg::CNT_MAX) tbl_cnt[s] = tbl_cnt[s] + 1'b1;
        if (tbl_cnt[s] >= cur_limit) begin
          tbl_lend[s] = now + cur_lockout;
          v.started   = 1'b1;
        end
        v.count = tbl_cnt[s];
      end
      default: begin
        empty_slot(s);
      end
    endcase
    return v;
  endfunction

  // ------------------------------------------------------------ result check
  function automatic void flag_field(string name, logic [7:0] want, logic [7:0] got);
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    mismatch_count++;
  endfunction

  always @(posedge clk) begin : rsp_check
    verdict_t want;
    verdict_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.locked  = rsp_if.locked;
      got.started = rsp_if.lockout_started;
      got.count   = rsp_if.fail_count;
      got.slot    = rsp_if.slot_index;
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing owed: expected none got %h", $time, got);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (got.locked !== want.locked) flag_field("locked", want.locked, got.locked);
        if (got.started !== want.started)
          flag_field("lockout_started", want.started, got.started);
        if (got.count !== want.count) flag_field("fail_count", want.count, got.count);
        if (got.slot !== want.slot) flag_field("slot_index", want.slot, got.slot);
        rsp_checked++;
        if (got.started === 1'b1) lockouts_started++;
        if (got.locked === 1'b1) locked_hits++;
      end
    end
  end

  // ------------------------------------------------------------------ idling
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!sink_stalls) begin
      rsp_if.ready <= 1'b1;
    end else if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      stall_left   <= pick_gap();
    end
  end

  // ------------------------------------------------------------ request side
  task automatic send_req(flt_pkg::flt_action_t act, logic [flt_pkg::KEY_W-1:0] key,
                          logic [flt_pkg::TIME_W-1:0] now);
    int unsigned gap;
    gap = source_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.key_low  <= key[flt_pkg::KEY_LO_W-1:0];
    req_if.key_high <= key[flt_pkg::KEY_W-1:flt_pkg::KEY_LO_W];
    req_if.now_ms   <= now;
    do @(posedge clk); while (!req_if.ready);
    verdict_q.push_back(lockout_verdict(act, key, now));
    req_sent++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- APB port
  // psel stays high across back-to-back transfers; callers drop it at the end.
  task automatic write_reg(logic [1:0] idx, logic [flt_pkg::CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= flt_pkg::CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      flt_pkg::REG_WINDOW:  cur_window  = value;
      flt_pkg::REG_LOCKOUT: cur_lockout = value;
      default:              cur_limit   = value[flt_pkg::CNT_W-1:0];
    endcase
  endtask

  task automatic read_back(logic [1:0] idx, logic [flt_pkg::CFG_DW-1:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= flt_pkg::CFG_AW'({idx, 2'b00});
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $display("%0t: register %0d expected %h got %h", $time, idx, want, cfg_prdata);
      mismatch_count++;
    end
  endtask

  task automatic set_config(logic [flt_pkg::TIME_W-1:0] window,
                            logic [flt_pkg::TIME_W-1:0] lockout,
                            logic [flt_pkg::CNT_W-1:0] limit);
    wait_idle();
    write_reg(flt_pkg::REG_WINDOW, window);
    write_reg(flt_pkg::REG_LOCKOUT, lockout);
    write_reg(flt_pkg::REG_LIMIT, flt_pkg::CFG_DW'(limit));
    read_back(flt_pkg::REG_WINDOW, cur_window);
    read_back(flt_pkg::REG_LOCKOUT, cur_lockout);
    read_back(flt_pkg::REG_LIMIT, flt_pkg::CFG_DW'(cur_limit));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // ------------------------------------------------------------- key helpers
  function automatic logic [flt_pkg::KEY_W-1:0] rand_name(int unsigned len);
    logic [flt_pkg::KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Fill the bytes past the terminator with garbage; the key must still match.
  function automatic logic [flt_pkg::KEY_W-1:0] add_junk(logic [flt_pkg::KEY_W-1:0] k);
    logic [flt_pkg::KEY_W-1:0] r;
    logic                      past;
    r    = k;
    past = 1'b0;
    for (int i = 0; i < flt_pkg::KEY_BYTES; i++) begin
      if (past) r[8*i +: 8] = 8'($urandom);
      else if (r[8*i +: 8] == 8'h00) past = 1'b1;
    end
    return r;
  endfunction

  function automatic void build_pool();
    logic [7:0] top;
    for (int i = 0; i < POOL; i++)
      user_pool[i] = rand_name($urandom_range(1, flt_pkg::KEY_BYTES));
    user_pool[0] = rand_name(flt_pkg::KEY_BYTES);
    // same name as user 0 except the last byte
    top          = user_pool[0][flt_pkg::KEY_W-1 -: 8];
    user_pool[1] = user_pool[0];
    user_pool[1][flt_pkg::KEY_W-1 -: 8] = (top == 8'hFF) ? 8'h01 : top + 8'h01;
    user_pool[2] = rand_name(3);
  endfunction

  function automatic void advance_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)      clock_ms += 32'($urandom_range(0, 400));
    else if (r < 75) clock_ms += 32'($urandom_range(0, 4000));
    else if (r < 90) clock_ms += 32'($urandom_range(0, 80000));
    else if (r < 95) clock_ms += 32'($urandom_range(0, 32'h7FFF_FFFF));
    else if (r < 98) clock_ms = $urandom;
    else             clock_ms -= 32'($urandom_range(0, 1000));
  endfunction

  task automatic run_mix(int unsigned n_items, int unsigned clear_pct, int unsigned fail_pct,
                         int unsigned hot_pct, int unsigned pool_n, int unsigned noise_pct);
    flt_pkg::flt_action_t      act;
    logic [flt_pkg::KEY_W-1:0] key;
    int unsigned               r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < clear_pct / 4)             act = flt_pkg::ACT_CLEAR_ALL;
      else if (r < clear_pct)            act = flt_pkg::ACT_CLEAR_USER;
      else if (r < clear_pct + fail_pct) act = flt_pkg::ACT_FAIL;
      else                               act = flt_pkg::ACT_CHECK;
      r = $urandom_range(0, 99);
      if (r < hot_pct)                  key = user_pool[0];
      else if (r < 100 - noise_pct)     key = user_pool[$urandom_range(0, pool_n - 1)];
      else if (r < 100 - noise_pct / 3)
        key = flt_pkg::KEY_W'({$urandom, $urandom, $urandom, $urandom});
      else                              key = '0;
      if ($urandom_range(0, 3) == 0) key = add_junk(key);
      advance_ms();
      send_req(act, key, clock_ms);
    end
  endtask

  // ------------------------------------------------------------------- tests
  task automatic test_register_access();
    read_back(flt_pkg::REG_WINDOW, flt_pkg::WINDOW_RST);
    read_back(flt_pkg::REG_LOCKOUT, flt_pkg::LOCKOUT_RST);
    read_back(flt_pkg::REG_LIMIT, flt_pkg::CFG_DW'(flt_pkg::LIMIT_RST));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_lockout_cycle();
    logic [flt_pkg::KEY_W-1:0] k;
    k = user_pool[2];
    send_req(flt_pkg::ACT_CHECK, k, 32'd1000);
    send_req(flt_pkg::ACT_FAIL, k, 32'd1000);
    send_req(flt_pkg::ACT_FAIL, add_junk(k), 32'd2000);
    send_req(flt_pkg::ACT_FAIL, k, 32'd3000);
    send_req(flt_pkg::ACT_CHECK, k, 32'd4000);
    send_req(flt_pkg::ACT_CHECK, k, 32'd32999);
    send_req(flt_pkg::ACT_CHECK, k, 32'd33000);
    send_req(flt_pkg::ACT_FAIL, k, 32'd60000);
    send_req(flt_pkg::ACT_FAIL, k, 32'd60001);
    send_req(flt_pkg::ACT_CLEAR_USER, add_junk(k), 32'd60002);
    send_req(flt_pkg::ACT_CHECK, k, 32'd60003);
  endtask

  task automatic test_key_forms();
    send_req(flt_pkg::ACT_CHECK, '0, 32'd100);
    send_req(flt_pkg::ACT_FAIL, add_junk('0), 32'd200);
    send_req(flt_pkg::ACT_CHECK, user_pool[0], 32'd300);
    send_req(flt_pkg::ACT_FAIL, user_pool[1], 32'd400);
    send_req(flt_pkg::ACT_FAIL, {flt_pkg::KEY_W{1'b1}}, 32'd500);
    // overflow the table so the oldest window start gets evicted
    for (int i = 3; i < POOL; i++) send_req(flt_pkg::ACT_FAIL, user_pool[i], 32'(1000 * i));
    send_req(flt_pkg::ACT_CHECK, user_pool[0], 32'd20000);
    send_req(flt_pkg::ACT_CLEAR_ALL, user_pool[3], 32'd20100);
    send_req(flt_pkg::ACT_CHECK, '0, 32'd20200);
  endtask

  task automatic test_limit_and_wrap();
    // lockout end lands exactly on zero
    set_config(flt_pkg::WINDOW_RST, 32'h0000_1000, 8'd0);
    send_req(flt_pkg::ACT_FAIL, user_pool[4], 32'hFFFF_F000);
    send_req(flt_pkg::ACT_CHECK, user_pool[4], 32'hFFFF_F005);
    set_config(32'd1, 32'hFFFF_FFFF, 8'd1);
    send_req(flt_pkg::ACT_FAIL, user_pool[5], 32'd100);
    send_req(flt_pkg::ACT_CHECK, user_pool[5], 32'd99);
    send_req(flt_pkg::ACT_CHECK, user_pool[5], 32'd98);
    set_config(32'd0, 32'd0, 8'd2);
    send_req(flt_pkg::ACT_FAIL, user_pool[6], 32'd500);
    send_req(flt_pkg::ACT_FAIL, user_pool[6], 32'd500);
    send_req(flt_pkg::ACT_CHECK, user_pool[6], 32'd500);
  endtask

  task automatic test_count_saturation();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, flt_pkg::CNT_MAX);
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_req(flt_pkg::ACT_CLEAR_ALL, '0, clock_ms);
    for (int i = 0; i < 300; i++) begin
      advance_ms();
      if (i % 10 == 9) send_req(flt_pkg::ACT_CHECK, user_pool[1 + i % 3], clock_ms);
      else send_req(flt_pkg::ACT_FAIL, user_pool[0], clock_ms);
    end
    send_req(flt_pkg::ACT_CHECK, user_pool[0], clock_ms);
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  task automatic test_random_defaults();
    set_config(flt_pkg::WINDOW_RST, flt_pkg::LOCKOUT_RST, flt_pkg::LIMIT_RST);
    run_mix(100, 10, 45, 15, POOL, 10);
  endtask

  task automatic test_random_short_windows();
    set_config(32'd1000, 32'd500, 8'd1);
    run_mix(120, 8, 50, 20, POOL, 8);
    set_config(32'd1, 32'd1, 8'd2);
    sink_stalls = 1'b0;
    run_mix(60, 8, 55, 10, POOL, 8);
    sink_stalls = 1'b1;
  endtask

  initial begin
    req_if.valid    = 1'b0;
    req_if.action   = flt_pkg::ACT_CHECK;
    req_if.key_low  = '0;
    req_if.key_high = '0;
    req_if.now_ms   = '0;
    rsp_if.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    cur_window      = flt_pkg::WINDOW_RST;
    cur_lockout     = flt_pkg::LOCKOUT_RST;
    cur_limit       = flt_pkg::LIMIT_RST;
    for (int s = 0; s < NSLOT; s++) empty_slot(s);
    clock_ms    = '0;
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    build_pool();
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_lockout_cycle();
    test_key_forms();
    test_limit_and_wrap();
    test_count_saturation();
    test_random_defaults();
    test_random_short_windows();
    wait_idle();

    $display("%0d requests sent, %0d results compared, %0d mismatches", req_sent,
             rsp_checked, mismatch_count);
    $display("lockouts started %0d, locked checks %0d, over seven register settings",
             lockouts_started, locked_hits);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
